@@ src/s2c_pkg.sv @@
// Shared constants and CORDIC angle table for the spherical to Cartesian converter.
`default_nettype none
package s2c_pkg;
	localparam int CORDIC_STAGES = 24;
	localparam int SC_LAT = CORDIC_STAGES + 3;
	localparam int TOT_LAT = SC_LAT + 3;
	localparam logic [32:0] TWO_OVER_PI = 33'h0A2F9836E;
	localparam logic signed [33:0] GAIN = 34'sh026DD3B6A;
	localparam logic signed [31:0] ONE_Q30 = 32'sh40000000;
	localparam logic signed [35:0] OUT_MAX = 36'sh0FFFFFFFF;
	localparam logic [31:0] ARC_TAB [32] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
		32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
	};
endpackage
`default_nettype wire

@@ src/s2c_sincos.sv @@
// Pipelined sine and cosine: phase scaling, octant reduction, CORDIC stages, clamp.
`default_nettype none
module s2c_sincos (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [31:0] angle,
	output logic signed [31:0]      cos_out,
	output logic signed [31:0]      sin_out
);
	localparam int N = s2c_pkg::CORDIC_STAGES;

	logic [31:0] ph_s1;
	logic [1:0]  q_s2;
	logic signed [32:0] z0_s2;
	logic signed [64:0] prod;
	logic [31:0] phr;
	logic [31:0] res;

	logic signed [33:0] cx_s [N+1];
	logic signed [33:0] cy_s [N+1];
	logic signed [32:0] cz_s [N+1];
	logic [1:0]         cq_s [N+1];

	assign prod = angle * $signed(s2c_pkg::TWO_OVER_PI);
	assign phr  = ph_s1 + 32'h20000000;
	assign res  = ph_s1 - {phr[31:30], 30'd0};

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s1 <= prod[61:30];
			q_s2  <= phr[31:30];
			z0_s2 <= {res[31], res};
		end
	end

	assign cx_s[0] = s2c_pkg::GAIN;
	assign cy_s[0] = '0;
	assign cz_s[0] = z0_s2;
	assign cq_s[0] = q_s2;

	for (genvar i = 0; i < N; i++) begin : g_stage
		localparam logic signed [32:0] ARC = {1'b0, s2c_pkg::ARC_TAB[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				if (!cz_s[i][32]) begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - ARC;
				end else begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + ARC;
				end
				cq_s[i+1] <= cq_s[i];
			end
		end
	end

	logic signed [33:0] c_raw, s_raw;

	always_comb begin
		case (cq_s[N])
			2'd0: begin c_raw = cx_s[N];  s_raw = cy_s[N];  end
			2'd1: begin c_raw = -cy_s[N]; s_raw = cx_s[N];  end
			2'd2: begin c_raw = -cx_s[N]; s_raw = -cy_s[N]; end
			default: begin c_raw = cy_s[N]; s_raw = -cx_s[N]; end
		endcase
	end

	function automatic logic signed [31:0] clamp(input logic signed [33:0] v);
		if (v > 34'(s2c_pkg::ONE_Q30)) return s2c_pkg::ONE_Q30;
		if (v < -34'(s2c_pkg::ONE_Q30)) return -s2c_pkg::ONE_Q30;
		return v[31:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			cos_out <= clamp(c_raw);
			sin_out <= clamp(s_raw);
		end
	end
endmodule
`default_nettype wire

@@ src/spherical_to_cartesian_point.sv @@
// Top level: spherical to Cartesian point conversion, fully pipelined.
// Usage:
//   Input stream s_*: one point per transaction, tdata = polar_angle [31:0],
//   azimuth [63:32], radius [95:64]. Angles are signed Q4.28 radians, the
//   radius unsigned Q16.16.
//   Output stream m_*: tdata = x_pos [32:0], y_pos [65:33], z_pos [98:66],
//   zero padded to 104 bits, signed Q16.16 rounded to nearest.
//   Throughput: one point per cycle while the output does not stall. The
//   pipeline has one register per CORDIC iteration plus the phase multiply,
//   octant reduction, quadrant/clamp and three multiply and rounding
//   stages.
//   Reset clears all valid bits; the pipeline holds no other state.
//   When the receiver stalls with a result waiting, the whole pipeline
//   freezes and s_tready drops; nothing is lost or repeated. Bubbles move
//   forward freely while the output register is empty.
`default_nettype none
module spherical_to_cartesian_point (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [95:0]  s_tdata,   // polar_angle, azimuth, radius
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [103:0]      m_tdata    // x_pos, y_pos, z_pos, zero pad
);
	localparam int SL = s2c_pkg::SC_LAT;
	localparam int TL = s2c_pkg::TOT_LAT;

	logic en;
	logic [TL-1:0] vld_q;
	logic signed [31:0] ct, st, cp, sp;
	logic [31:0] rad_s [SL];

	assign en = !vld_q[TL-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[TL-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[TL-2:0], s_tvalid};
		end
	end

	s2c_sincos u_theta (
		.clk(clk), .en(en), .angle($signed(s_tdata[31:0])),
		.cos_out(ct), .sin_out(st)
	);
	s2c_sincos u_phi (
		.clk(clk), .en(en), .angle($signed(s_tdata[63:32])),
		.cos_out(cp), .sin_out(sp)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s[0] <= s_tdata[95:64];
			for (int k = 1; k < SL; k++) rad_s[k] <= rad_s[k-1];
		end
	end

	// sin(theta)*cos(phi), sin(theta)*sin(phi), rounded to Q.30
	logic signed [63:0] pxx, pyy;
	logic signed [63:0] rxx, ryy;
	logic signed [31:0] fx_s1, fy_s1, fz_s1;
	logic [31:0] r_s1;

	assign pxx = st * cp;
	assign pyy = st * sp;
	assign rxx = (pxx + 64'sh20000000) >>> 30;
	assign ryy = (pyy + 64'sh20000000) >>> 30;

	always_ff @(posedge clk) begin
		if (en) begin
			fx_s1 <= rxx[31:0];
			fy_s1 <= ryy[31:0];
			fz_s1 <= ct;
			r_s1  <= rad_s[SL-1];
		end
	end

	logic signed [64:0] mx_s2, my_s2, mz_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s2 <= $signed({1'b0, r_s1}) * fx_s1;
			my_s2 <= $signed({1'b0, r_s1}) * fy_s1;
			mz_s2 <= $signed({1'b0, r_s1}) * fz_s1;
		end
	end

	function automatic logic [32:0] scale(input logic signed [64:0] m);
		logic signed [65:0] t;
		logic signed [35:0] v;
		t = ({m[64], m} + 66'sh20000000) >>> 30;
		v = t[35:0];
		if (v > s2c_pkg::OUT_MAX) v = s2c_pkg::OUT_MAX;
		if (v < -s2c_pkg::OUT_MAX) v = -s2c_pkg::OUT_MAX;
		return v[32:0];
	endfunction

	logic [32:0] x_s3, y_s3, z_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3 <= scale(mx_s2);
			y_s3 <= scale(my_s2);
			z_s3 <= scale(mz_s2);
		end
	end

	assign m_tdata = {5'd0, z_s3, y_s3, x_s3};
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench for spherical_to_cartesian_point: streams points, predicts x/y/z and checks each result.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	localparam longint XYZ_MAX = 64'sd4294967295;
	localparam int LIMIT_CYCLES = 400000;
	localparam int TAIL_CYCLES = s2c_pkg::TOT_LAT + 20;

	typedef struct packed {
		logic [32:0] z_pos;
		logic [32:0] y_pos;
		logic [32:0] x_pos;
	} xyz_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [95:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [103:0] m_tdata;

	xyz_t xyz_expected[$];
	int n_errors = 0;
	int n_points = 0;
	int n_results = 0;
	int cycle = 0;
	bit send_idle_en = 1'b1;
	bit recv_idle_en = 1'b1;
	int recv_hold = 0;

	spherical_to_cartesian_point i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	// cosine and sine of a Q4.28 angle, Q2.30
	function automatic void angle_cos_sin(input logic [31:0] ang, output longint c,
		output longint s);
		longint a, zz, xx, yy, dx, dy;
		logic [63:0] prod;
		logic [31:0] ph, oct, res;
		int sh;
		a = longint'($signed(ang));
		prod = a * longint'(64'h00000000A2F9836E);
		ph = prod[61:30];
		oct = ((ph + 32'h20000000) >> 30) & 32'd3;
		res = ph - (oct << 30);
		zz = longint'($signed(res));
		xx = longint'(s2c_pkg::GAIN);
		yy = 0;
		for (int i = 0; i < s2c_pkg::CORDIC_STAGES; i++) begin
			sh = i % 32;
			dx = floor_shr(yy, sh);
			dy = floor_shr(xx, sh);
			if (zz >= 0) begin
				xx -= dx; yy += dy; zz -= longint'(s2c_pkg::ARC_TAB[sh]);
			end else begin
				xx += dx; yy -= dy; zz += longint'(s2c_pkg::ARC_TAB[sh]);
			end
		end
		case (oct)
			0: begin c = xx; s = yy; end
			1: begin c = -yy; s = xx; end
			2: begin c = -xx; s = -yy; end
			default: begin c = yy; s = -xx; end
		endcase
		if (c > (64'sd1 <<< 30)) c = 64'sd1 <<< 30;
		if (c < -(64'sd1 <<< 30)) c = -(64'sd1 <<< 30);
		if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
		if (s < -(64'sd1 <<< 30)) s = -(64'sd1 <<< 30);
	endfunction

	function automatic longint round30(longint v);
		return floor_shr(v + (64'sd1 <<< 29), 30);
	endfunction

	function automatic logic [32:0] scale_radius(longint r, longint f);
		longint v;
		v = round30(r * f);
		if (v > XYZ_MAX) v = XYZ_MAX;
		if (v < -XYZ_MAX) v = -XYZ_MAX;
		return v[32:0];
	endfunction

	function automatic xyz_t spherical_to_xyz(logic [31:0] th, logic [31:0] ph, logic [31:0] rad);
		longint ct, st, cp, sp, r;
		xyz_t o;
		angle_cos_sin(th, ct, st);
		angle_cos_sin(ph, cp, sp);
		r = longint'({32'd0, rad});
		o.x_pos = scale_radius(r, round30(st * cp));
		o.y_pos = scale_radius(r, round30(st * sp));
		o.z_pos = scale_radius(r, ct);
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [32:0] got, input logic [32:0] exp);
		$display("mismatch %s at result %0d: got %h expected %h", what, n_results, got, exp);
		n_errors++;
	endtask

	task automatic send_point(input logic [31:0] th, input logic [31:0] ph, input logic [31:0] rad);
		while (send_idle_en && $urandom_range(99) < 6) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {rad, ph, th};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		xyz_expected.push_back(spherical_to_xyz(th, ph, rad));
		n_points++;
		@(negedge clk);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (xyz_expected.size() != 0) @(negedge clk);
	endtask

	// receiver
	always @(negedge clk) begin
		if (recv_hold > 0) begin
			m_tready <= 1'b0;
			recv_hold <= recv_hold - 1;
		end else
			m_tready <= !(recv_idle_en && $urandom_range(99) < 6);
	end

	always @(posedge clk) begin
		xyz_t got, exp;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[98:0];
			if (xyz_expected.size() == 0) begin
				$display("unexpected transaction at cycle %0d", cycle);
				n_errors++;
			end else begin
				exp = xyz_expected.pop_front();
				if (got.x_pos !== exp.x_pos) report_mismatch("x_pos", got.x_pos, exp.x_pos);
				if (got.y_pos !== exp.y_pos) report_mismatch("y_pos", got.y_pos, exp.y_pos);
				if (got.z_pos !== exp.z_pos) report_mismatch("z_pos", got.z_pos, exp.z_pos);
			end
			n_results++;
		end
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > LIMIT_CYCLES) begin
			$display("timeout at cycle %0d", cycle);
			$display("[spherical_to_cartesian_point] ERROR");
			$finish;
		end
	end

	task automatic test_directed;
		logic [31:0] angles [10] = '{32'h00000000, 32'h7FFFFFFF, 32'h80000000, 32'h1921FB54,
			32'h3243F6A9, 32'hE6DE04AC, 32'h0C90FDAA, 32'h6487ED51, 32'hFFFFFFFF, 32'h00000001};
		for (int i = 0; i < 10; i++) send_point(angles[i], angles[9 - i], 32'hFFFFFFFF);
		send_point(32'h1921FB54, 32'h00000000, 32'h00000000);
		send_point(32'h7FFFFFFF, 32'h80000000, 32'h00000000);
		send_point(32'h0C90FDAA, 32'h0C90FDAA, 32'h00010000);
		send_point(32'h00000000, 32'h00000000, 32'h00000001);
		send_point(32'h3243F6A9, 32'h3243F6A9, 32'h80000000);
		send_point(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
		drain();
	endtask

	task automatic test_random(input int n);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3))
				0: send_point($urandom, $urandom, $urandom);
				1: send_point($urandom_range(32'h6487ED51), $urandom, $urandom_range(32'h00FFFFFF));
				2: send_point($urandom, $urandom, $urandom_range(32'hFFFFFFFF, 32'hFFFF0000));
				default: send_point($urandom_range(15) - 8, $urandom_range(15) - 8, $urandom_range(255));
			endcase
		end
	endtask

	task automatic test_full_rate;
		send_idle_en = 1'b0;
		recv_idle_en = 1'b0;
		test_random(300);
		send_idle_en = 1'b1;
		recv_idle_en = 1'b1;
		drain();
	endtask

	task automatic test_backpressure;
		@(negedge clk);
		recv_hold = 3 * s2c_pkg::TOT_LAT;
		send_idle_en = 1'b0;
		test_random(150);
		send_idle_en = 1'b1;
		drain();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(500);
		drain();
		test_full_rate();
		test_backpressure();
		test_random(330);
		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("covered %0d points: angle extremes, zero and full radius, random and", n_points);
		$display("full-rate streams, long output stall with input backpressure");
		if (n_errors == 0 && xyz_expected.size() == 0)
			$display("[spherical_to_cartesian_point] OK");
		else
			$display("[spherical_to_cartesian_point] ERROR");
		$finish;
	end
endmodule
`default_nettype wire
